// File: hw/rtl/hsfd_pkg.sv
// hsfd_pkg: shared constants, types and codes for the humidity slope fan decider
// used by hsfd_mac, hsfd_window and humidity_slope_fan_decider; no dependencies

package hsfd_pkg;

   // field widths
   localparam int HUM_W    = 7;
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 31;
   localparam int THR_W    = 10;
   localparam int MARGIN_W = 7;

   // store depths
   localparam int WIN_DEPTH  = 32;
   localparam int HIST_DEPTH = 6;
   localparam int WIN_AW     = $clog2(WIN_DEPTH);
   localparam int WIN_CW     = $clog2(WIN_DEPTH + 1);
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);
   localparam int ENTRY_W    = TIME_W + HUM_W;

   // sum and product widths of the least-squares terms
   localparam int SH_W    = HUM_W + WIN_CW;
   localparam int ST_W    = TIME_W + WIN_CW;
   localparam int SHT_W   = HUM_W + 1 + TIME_W + WIN_CW;
   localparam int SHH_W   = 2 * HUM_W + WIN_CW;
   localparam int NUM_W   = SHT_W + WIN_CW + 2;
   localparam int DEN_W   = SHH_W + WIN_CW + 2;
   localparam int CMP_W   = NUM_W + THR_W;
   localparam int MAC_A_W = SH_W + 1;
   localparam int MAC_B_W = NUM_W;
   localparam int PROD_W  = MAC_A_W + MAC_B_W;

   // stream word widths
   localparam int REQ_FIELDS_W = HUM_W + 2 * TIME_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = 8;

   // csr port
   localparam int CSR_AW = 2;
   localparam int CSR_DW = PERIOD_W;

   // reset values and fixed constants
   localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = PERIOD_W'(20 * 60 * 1000);
   localparam logic [THR_W-1:0]    RISE_RESET       = THR_W'(45);
   localparam logic [THR_W-1:0]    FLAT_RESET       = THR_W'(10);
   localparam logic [MARGIN_W-1:0] MARGIN_RESET     = MARGIN_W'(2);
   localparam logic [HUM_W-1:0]    HUM_MAX          = HUM_W'(100);
   localparam int                  HUNDRED          = 100;

   // operation codes carried in tuser
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef enum logic [CSR_AW-1:0] {
      CSR_MIN_PERIOD = 2'd0,
      CSR_RISE       = 2'd1,
      CSR_FLAT       = 2'd2,
      CSR_MARGIN     = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_T0,
      ST_HH,
      ST_HT,
      ST_N1,
      ST_N2,
      ST_D1,
      ST_D2,
      ST_R1,
      ST_R2,
      ST_F1,
      ST_F2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic append;
      logic rd_first;
      logic rd_next;
   } win_ctl_type;

endpackage

// File: hw/rtl/hsfd_mac.sv
// hsfd_mac: shared signed multiply-add unit, result = c + a*b or c - a*b
// depends on hsfd_pkg for operand widths

module hsfd_mac (
   input  logic signed [hsfd_pkg::MAC_A_W-1:0] mac_a,
   input  logic signed [hsfd_pkg::MAC_B_W-1:0] mac_b,
   input  logic signed [hsfd_pkg::CMP_W-1:0]   mac_c,
   input  logic                                mac_sub,
   output logic signed [hsfd_pkg::CMP_W-1:0]   mac_result
);

   logic signed [hsfd_pkg::PROD_W-1:0] product;
   logic signed [hsfd_pkg::CMP_W-1:0]  product_t;

   assign product   = mac_a * mac_b;
   // every product the sequencer asks for fits the accumulator width
   assign product_t = product[hsfd_pkg::CMP_W-1:0];

   always_comb begin
      if (mac_sub) begin
         mac_result = mac_c - product_t;
      end else begin
         mac_result = mac_c + product_t;
      end
   end

endmodule

// File: hw/rtl/hsfd_window.sv
// hsfd_window: circular sample store of humidity and timestamp pairs
// one write port for appends, one registered read port walking from the oldest entry
// depends on hsfd_pkg

module hsfd_window (
   input  logic                          clock,
   input  logic                          reset,
   input  hsfd_pkg::win_ctl_type         ctl,
   input  logic [hsfd_pkg::HUM_W-1:0]    wr_hum,
   input  logic [hsfd_pkg::TIME_W-1:0]   wr_time,
   output logic [hsfd_pkg::WIN_CW-1:0]   count,
   output logic [hsfd_pkg::HUM_W-1:0]    rd_hum,
   output logic [hsfd_pkg::TIME_W-1:0]   rd_time
);

   localparam logic [hsfd_pkg::WIN_AW-1:0] LAST_IDX = hsfd_pkg::WIN_AW'(hsfd_pkg::WIN_DEPTH - 1);
   localparam logic [hsfd_pkg::WIN_CW:0]   DEPTH_S  = (hsfd_pkg::WIN_CW + 1)'(hsfd_pkg::WIN_DEPTH);

   logic [hsfd_pkg::ENTRY_W-1:0] mem [hsfd_pkg::WIN_DEPTH];
   logic [hsfd_pkg::ENTRY_W-1:0] rd_data_ff;

   logic [hsfd_pkg::WIN_AW-1:0] head_ff, head_in;
   logic [hsfd_pkg::WIN_AW-1:0] rptr_ff, rptr_in;
   logic [hsfd_pkg::WIN_CW-1:0] count_ff, count_in;

   logic [hsfd_pkg::WIN_AW-1:0] wr_addr;
   logic [hsfd_pkg::WIN_AW-1:0] rd_addr;
   logic [hsfd_pkg::WIN_CW:0]   wr_sum;
   logic                        full;
   logic                        rd_en;

   function automatic logic [hsfd_pkg::WIN_AW-1:0] wrap_inc(
      input logic [hsfd_pkg::WIN_AW-1:0] v
   );
      logic [hsfd_pkg::WIN_AW-1:0] r;
      if (v == LAST_IDX) begin
         r = '0;
      end else begin
         r = v + 1'b1;
      end
      return r;
   endfunction

   assign full   = (count_ff == hsfd_pkg::WIN_CW'(hsfd_pkg::WIN_DEPTH));
   assign wr_sum = (hsfd_pkg::WIN_CW + 1)'(head_ff) + (hsfd_pkg::WIN_CW + 1)'(count_ff);
   assign rd_en  = ctl.rd_first | ctl.rd_next;

   always_comb begin
      // when full the new word overwrites the oldest one
      if (full) begin
         wr_addr = head_ff;
      end else if (wr_sum >= DEPTH_S) begin
         wr_addr = hsfd_pkg::WIN_AW'(wr_sum - DEPTH_S);
      end else begin
         wr_addr = hsfd_pkg::WIN_AW'(wr_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      rptr_in  = rptr_ff;
      rd_addr  = rptr_ff;
      if (ctl.append) begin
         if (full) begin
            head_in = wrap_inc(head_ff);
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (ctl.rd_first) begin
         rd_addr = head_ff;
         rptr_in = wrap_inc(head_ff);
      end else if (ctl.rd_next) begin
         rptr_in = wrap_inc(rptr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rptr_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rptr_ff  <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.append) begin
         mem[wr_addr] <= {wr_time, wr_hum};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign count   = count_ff;
   assign rd_hum  = rd_data_ff[hsfd_pkg::HUM_W-1:0];
   assign rd_time = rd_data_ff[hsfd_pkg::HUM_W +: hsfd_pkg::TIME_W];

endmodule

// File: hw/rtl/humidity_slope_fan_decider.sv
// humidity_slope_fan_decider: top level, sequencer, minimum history and csr bank
// depends on hsfd_pkg, hsfd_mac and hsfd_window
//
// Usage. Items arrive on the req_ stream; req_tuser picks the operation. A sample
// word (tuser 0) appends humidity and sample_time to a 32-deep window, dropping the
// oldest pair once full. An update word (tuser 1) tracks the running minimum, pushes
// it into a six-deep history each time min_period_ms has run out on now_ms, then
// fits the least-squares slope of time on humidity over the window and decides the
// fan. Every item gives one rsp_ word holding the fan decision; a sample word
// returns the decision held from the last update.
// Steps. A sample word passes through the execute and done states before its result
// is registered. An update word walks the window after a first read: each sample
// costs two passes through the single multiply-add unit (h*h, then h*t) fed by the
// window's single read port, and eight more passes form and test the slope fraction.
// An empty window skips the walk. req_tready is high only while the sequencer is
// idle, so the next word is taken in the cycle after the result is registered.
// Stalls. The result sits in an output register; the sequencer may go idle and take
// a new word while it waits. A finished result waits in its last step only if the
// previous result is still unclaimed.
// Reset. Synchronous, active high: empties the window and history, restores the
// csr defaults and clears the fan decision. No clearing pass is needed.

module humidity_slope_fan_decider (
   input  logic                                clock,
   input  logic                                reset,
   // slave stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // humidity [6:0], sample_time [38:7], now_ms [70:39], zero fill above
   input  logic [hsfd_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // op [0]
   input  logic                                req_tuser,
   // master stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // fan_on [0], zero fill above
   output logic [hsfd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // csr write port
   input  logic                                csr_wr_en,
   input  logic [hsfd_pkg::CSR_AW-1:0]         csr_addr,
   input  logic [hsfd_pkg::CSR_DW-1:0]         csr_wdata
);

   // csr bank
   logic [hsfd_pkg::PERIOD_W-1:0] min_period_ff;
   logic [hsfd_pkg::THR_W-1:0]    rise_thr_ff;
   logic [hsfd_pkg::THR_W-1:0]    flat_thr_ff;
   logic [hsfd_pkg::MARGIN_W-1:0] margin_ff;

   // control state
   hsfd_pkg::state_type           state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          fan_ff, fan_in;
   logic [hsfd_pkg::HUM_W-1:0]    run_min_ff, run_min_in;
   logic [hsfd_pkg::HIST_CW-1:0]  hcnt_ff, hcnt_in;
   logic [hsfd_pkg::PERIOD_W-1:0] time_left_ff, time_left_in;
   logic [hsfd_pkg::TIME_W-1:0]   last_time_ff, last_time_in;
   logic [hsfd_pkg::WIN_CW-1:0]   idx_ff, idx_in;

   // payload
   logic                          op_ff, op_in;
   logic [hsfd_pkg::HUM_W-1:0]    hum_ff, hum_in;
   logic [hsfd_pkg::TIME_W-1:0]   stime_ff, stime_in;
   logic [hsfd_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [hsfd_pkg::TIME_W-1:0]   t0_ff, t0_in;
   logic [hsfd_pkg::HUM_W-1:0]    h_ff, h_in;
   logic signed [hsfd_pkg::TIME_W-1:0] t_ff, t_in;
   logic [hsfd_pkg::SH_W-1:0]     sh_ff, sh_in;
   logic signed [hsfd_pkg::ST_W-1:0]   st_ff, st_in;
   logic signed [hsfd_pkg::SHT_W-1:0]  sht_ff, sht_in;
   logic [hsfd_pkg::SHH_W-1:0]    shh_ff, shh_in;
   logic signed [hsfd_pkg::NUM_W-1:0]  num_ff, num_in;
   logic signed [hsfd_pkg::DEN_W-1:0]  den_ff, den_in;
   logic signed [hsfd_pkg::CMP_W-1:0]  cmp_ff, cmp_in;
   logic                          rise_ff, rise_in;
   logic                          empty_ff, empty_in;
   logic                          rsp_fan_ff, rsp_fan_in;
   logic [hsfd_pkg::HUM_W-1:0]    hist_ff [hsfd_pkg::HIST_DEPTH];
   logic [hsfd_pkg::HUM_W-1:0]    hist_in [hsfd_pkg::HIST_DEPTH];

   // window and shared unit
   hsfd_pkg::win_ctl_type         win_ctl;
   logic [hsfd_pkg::WIN_CW-1:0]   win_count;
   logic [hsfd_pkg::HUM_W-1:0]    win_rd_hum;
   logic [hsfd_pkg::TIME_W-1:0]   win_rd_time;
   logic signed [hsfd_pkg::MAC_A_W-1:0] mac_a;
   logic signed [hsfd_pkg::MAC_B_W-1:0] mac_b;
   logic signed [hsfd_pkg::CMP_W-1:0]   mac_c;
   logic                          mac_sub;
   logic signed [hsfd_pkg::CMP_W-1:0]   mac_result;

   // helpers
   logic [hsfd_pkg::HUM_W-1:0]    min_new;
   logic [hsfd_pkg::TIME_W-1:0]   delta;
   logic                          delta_pos;
   logic [hsfd_pkg::TIME_W-1:0]   left_diff;
   logic                          idx_last;
   logic                          out_free;
   logic                          flat_ok;
   logic                          upd_fan;
   logic                          decision;

   hsfd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .wr_hum  (hum_ff),
      .wr_time (stime_ff),
      .count   (win_count),
      .rd_hum  (win_rd_hum),
      .rd_time (win_rd_time)
   );

   hsfd_mac u_mac (
      .mac_a      (mac_a),
      .mac_b      (mac_b),
      .mac_c      (mac_c),
      .mac_sub    (mac_sub),
      .mac_result (mac_result)
   );

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= hsfd_pkg::MIN_PERIOD_RESET;
         rise_thr_ff   <= hsfd_pkg::RISE_RESET;
         flat_thr_ff   <= hsfd_pkg::FLAT_RESET;
         margin_ff     <= hsfd_pkg::MARGIN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            hsfd_pkg::CSR_MIN_PERIOD: min_period_ff <= csr_wdata[hsfd_pkg::PERIOD_W-1:0];
            hsfd_pkg::CSR_RISE:       rise_thr_ff   <= csr_wdata[hsfd_pkg::THR_W-1:0];
            hsfd_pkg::CSR_FLAT:       flat_thr_ff   <= csr_wdata[hsfd_pkg::THR_W-1:0];
            hsfd_pkg::CSR_MARGIN:     margin_ff     <= csr_wdata[hsfd_pkg::MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign min_new   = (hum_ff < run_min_ff) ? hum_ff : run_min_ff;
   assign delta     = now_ff - last_time_ff;
   assign delta_pos = (delta != '0) && !delta[hsfd_pkg::TIME_W-1];
   assign left_diff = {1'b0, time_left_ff} - delta;
   assign idx_last  = (hsfd_pkg::WIN_CW'(idx_ff + 1'b1) == win_count);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // flat reading check against the oldest stored minimum
   assign flat_ok = (num_ff > 0) && (cmp_ff < 0) && (hcnt_ff != '0) &&
                    ({1'b0, hum_ff} > ({1'b0, hist_ff[0]} + {1'b0, margin_ff}));
   assign upd_fan  = !empty_ff && (den_ff > 0) && (rise_ff || flat_ok);
   assign decision = (op_ff == hsfd_pkg::OP_UPDATE) ? upd_fan : fan_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      fan_in       = fan_ff;
      run_min_in   = run_min_ff;
      hcnt_in      = hcnt_ff;
      time_left_in = time_left_ff;
      last_time_in = last_time_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      hum_in       = hum_ff;
      stime_in     = stime_ff;
      now_in       = now_ff;
      t0_in        = t0_ff;
      h_in         = h_ff;
      t_in         = t_ff;
      sh_in        = sh_ff;
      st_in        = st_ff;
      sht_in       = sht_ff;
      shh_in       = shh_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      cmp_in       = cmp_ff;
      rise_in      = rise_ff;
      empty_in     = empty_ff;
      rsp_fan_in   = rsp_fan_ff;
      hist_in      = hist_ff;
      win_ctl      = '0;
      mac_a        = '0;
      mac_b        = '0;
      mac_c        = '0;
      mac_sub      = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         hsfd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               hum_in   = req_tdata[hsfd_pkg::HUM_W-1:0];
               stime_in = req_tdata[hsfd_pkg::HUM_W +: hsfd_pkg::TIME_W];
               now_in   = req_tdata[hsfd_pkg::HUM_W + hsfd_pkg::TIME_W +: hsfd_pkg::TIME_W];
               state_in = hsfd_pkg::ST_EXEC;
            end
         end
         hsfd_pkg::ST_EXEC: begin
            if (op_ff == hsfd_pkg::OP_SAMPLE) begin
               win_ctl.append = 1'b1;
               state_in       = hsfd_pkg::ST_DONE;
            end else begin
               run_min_in   = min_new;
               last_time_in = now_ff;
               if (delta_pos) begin
                  if (left_diff[hsfd_pkg::TIME_W-1]) begin
                     // period ran out: store the minimum and restart tracking
                     time_left_in = min_period_ff;
                     run_min_in   = hsfd_pkg::HUM_MAX;
                     if (hcnt_ff == hsfd_pkg::HIST_CW'(hsfd_pkg::HIST_DEPTH)) begin
                        for (int k = 0; k < hsfd_pkg::HIST_DEPTH - 1; k++) begin
                           hist_in[k] = hist_ff[k+1];
                        end
                        hist_in[hsfd_pkg::HIST_DEPTH-1] = min_new;
                     end else begin
                        hist_in[hcnt_ff[hsfd_pkg::HIST_AW-1:0]] = min_new;
                        hcnt_in = hcnt_ff + 1'b1;
                     end
                  end else begin
                     time_left_in = left_diff[hsfd_pkg::PERIOD_W-1:0];
                  end
               end
               if (win_count == '0) begin
                  empty_in = 1'b1;
                  state_in = hsfd_pkg::ST_DONE;
               end else begin
                  empty_in         = 1'b0;
                  win_ctl.rd_first = 1'b1;
                  state_in         = hsfd_pkg::ST_T0;
               end
            end
         end
         hsfd_pkg::ST_T0: begin
            t0_in    = win_rd_time;
            sh_in    = '0;
            st_in    = '0;
            sht_in   = '0;
            shh_in   = '0;
            idx_in   = '0;
            state_in = hsfd_pkg::ST_HH;
         end
         hsfd_pkg::ST_HH: begin
            mac_a  = hsfd_pkg::MAC_A_W'($signed({1'b0, win_rd_hum}));
            mac_b  = hsfd_pkg::MAC_B_W'($signed({1'b0, win_rd_hum}));
            mac_c  = hsfd_pkg::CMP_W'($signed({1'b0, shh_ff}));
            shh_in = mac_result[hsfd_pkg::SHH_W-1:0];
            h_in   = win_rd_hum;
            t_in   = win_rd_time - t0_ff;
            // fetch the next word while this one finishes
            if (!idx_last) begin
               win_ctl.rd_next = 1'b1;
            end
            state_in = hsfd_pkg::ST_HT;
         end
         hsfd_pkg::ST_HT: begin
            mac_a  = hsfd_pkg::MAC_A_W'($signed({1'b0, h_ff}));
            mac_b  = hsfd_pkg::MAC_B_W'(t_ff);
            mac_c  = hsfd_pkg::CMP_W'(sht_ff);
            sht_in = mac_result[hsfd_pkg::SHT_W-1:0];
            sh_in  = sh_ff + hsfd_pkg::SH_W'(h_ff);
            st_in  = st_ff + hsfd_pkg::ST_W'(t_ff);
            idx_in = idx_ff + 1'b1;
            if (idx_last) begin
               state_in = hsfd_pkg::ST_N1;
            end else begin
               state_in = hsfd_pkg::ST_HH;
            end
         end
         hsfd_pkg::ST_N1: begin
            mac_a    = hsfd_pkg::MAC_A_W'($signed({1'b0, win_count}));
            mac_b    = hsfd_pkg::MAC_B_W'(sht_ff);
            num_in   = mac_result[hsfd_pkg::NUM_W-1:0];
            state_in = hsfd_pkg::ST_N2;
         end
         hsfd_pkg::ST_N2: begin
            mac_a    = hsfd_pkg::MAC_A_W'($signed({1'b0, sh_ff}));
            mac_b    = hsfd_pkg::MAC_B_W'(st_ff);
            mac_c    = hsfd_pkg::CMP_W'(num_ff);
            mac_sub  = 1'b1;
            num_in   = mac_result[hsfd_pkg::NUM_W-1:0];
            state_in = hsfd_pkg::ST_D1;
         end
         hsfd_pkg::ST_D1: begin
            mac_a    = hsfd_pkg::MAC_A_W'($signed({1'b0, win_count}));
            mac_b    = hsfd_pkg::MAC_B_W'($signed({1'b0, shh_ff}));
            den_in   = mac_result[hsfd_pkg::DEN_W-1:0];
            state_in = hsfd_pkg::ST_D2;
         end
         hsfd_pkg::ST_D2: begin
            mac_a    = hsfd_pkg::MAC_A_W'($signed({1'b0, sh_ff}));
            mac_b    = hsfd_pkg::MAC_B_W'($signed({1'b0, sh_ff}));
            mac_c    = hsfd_pkg::CMP_W'(den_ff);
            mac_sub  = 1'b1;
            den_in   = mac_result[hsfd_pkg::DEN_W-1:0];
            state_in = hsfd_pkg::ST_R1;
         end
         hsfd_pkg::ST_R1: begin
            mac_a    = hsfd_pkg::MAC_A_W'(hsfd_pkg::HUNDRED);
            mac_b    = hsfd_pkg::MAC_B_W'(num_ff);
            cmp_in   = mac_result;
            state_in = hsfd_pkg::ST_R2;
         end
         hsfd_pkg::ST_R2: begin
            mac_a    = hsfd_pkg::MAC_A_W'($signed({1'b0, rise_thr_ff}));
            mac_b    = hsfd_pkg::MAC_B_W'(den_ff);
            mac_c    = cmp_ff;
            mac_sub  = 1'b1;
            cmp_in   = mac_result;
            state_in = hsfd_pkg::ST_F1;
         end
         hsfd_pkg::ST_F1: begin
            rise_in  = (cmp_ff > 0);
            mac_a    = hsfd_pkg::MAC_A_W'(hsfd_pkg::HUNDRED);
            mac_b    = hsfd_pkg::MAC_B_W'(num_ff);
            cmp_in   = mac_result;
            state_in = hsfd_pkg::ST_F2;
         end
         hsfd_pkg::ST_F2: begin
            mac_a    = hsfd_pkg::MAC_A_W'($signed({1'b0, flat_thr_ff}));
            mac_b    = hsfd_pkg::MAC_B_W'(den_ff);
            mac_c    = cmp_ff;
            mac_sub  = 1'b1;
            cmp_in   = mac_result;
            state_in = hsfd_pkg::ST_DONE;
         end
         hsfd_pkg::ST_DONE: begin
            if (out_free) begin
               fan_in       = decision;
               rsp_fan_in   = decision;
               rsp_valid_in = 1'b1;
               state_in     = hsfd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hsfd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hsfd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fan_ff       <= 1'b0;
         run_min_ff   <= hsfd_pkg::HUM_MAX;
         hcnt_ff      <= '0;
         time_left_ff <= hsfd_pkg::MIN_PERIOD_RESET;
         last_time_ff <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fan_ff       <= fan_in;
         run_min_ff   <= run_min_in;
         hcnt_ff      <= hcnt_in;
         time_left_ff <= time_left_in;
         last_time_ff <= last_time_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      hum_ff     <= hum_in;
      stime_ff   <= stime_in;
      now_ff     <= now_in;
      t0_ff      <= t0_in;
      h_ff       <= h_in;
      t_ff       <= t_in;
      sh_ff      <= sh_in;
      st_ff      <= st_in;
      sht_ff     <= sht_in;
      shh_ff     <= shh_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      cmp_ff     <= cmp_in;
      rise_ff    <= rise_in;
      empty_ff   <= empty_in;
      rsp_fan_ff <= rsp_fan_in;
      hist_ff    <= hist_in;
   end

   // no word is taken while reset is held
   assign req_tready = (state_ff == hsfd_pkg::ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = hsfd_pkg::RSP_TDATA_W'(rsp_fan_ff);

`ifndef SYNTHESIS
   a_win_count_range: assert property (@(posedge clock) disable iff (reset)
      win_count <= hsfd_pkg::WIN_CW'(hsfd_pkg::WIN_DEPTH))
      else $error("window count beyond depth");

   a_hist_count_range: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= hsfd_pkg::HIST_CW'(hsfd_pkg::HIST_DEPTH))
      else $error("history count beyond depth");

   a_accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == hsfd_pkg::ST_EXEC))
      else $error("accepted word did not start execution");

   a_walk_needs_samples: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hsfd_pkg::ST_HH) |-> (win_count != '0))
      else $error("window walk with empty window");

   a_done_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hsfd_pkg::ST_DONE && out_free) |=>
      (rsp_tvalid && state_ff == hsfd_pkg::ST_IDLE))
      else $error("finished item did not reach the output register");
`endif

endmodule
